// ----- src/clcd_pkg.sv -----
// Shared types, constants and helper functions of the character LCD text writer.
`timescale 1ns / 1ps
package clcd_pkg;

  localparam int unsigned COL_W      = 6;
  localparam int unsigned CURSOR_W   = 7;
  localparam int unsigned ROW_W      = 3;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 6'd16;
  localparam logic [ROW_W-1:0] LINE_COUNT_RST   = 3'd2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CMD_SET_ADDR = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_LINE_COUNT   = 2'd1
  } clcd_cfg_e;

  // One queue entry holds the one or two bytes that a single input item causes.
  typedef struct packed {
    logic              two;
    logic [CHAR_W-1:0] byte0;
    logic              rs0;
    logic [CHAR_W-1:0] byte1;
    logic              rs1;
  } clcd_entry_t;

  typedef struct packed {
    logic [1:0] step;
    logic       busy;
  } clcd_back_status_t;

  function automatic logic [CURSOR_W-1:0] row_offset(input logic [1:0] sel);
    logic [CURSOR_W-1:0] off;
    case (sel)
      2'd0:    off = 7'h00;
      2'd1:    off = 7'h40;
      2'd2:    off = 7'h14;
      2'd3:    off = 7'h54;
      default: off = 7'h00;
    endcase
    return off;
  endfunction

  // A row at or beyond the line count falls back to the top line.
  function automatic logic [ROW_W-1:0] fix_row(input logic [ROW_W-1:0] row,
                                               input logic [ROW_W-1:0] lines);
    return (row >= lines) ? '0 : row;
  endfunction

  function automatic logic [CHAR_W-1:0] set_address(input logic [CURSOR_W-1:0] col,
                                                    input logic [ROW_W-1:0]    row);
    logic [CURSOR_W-1:0] sum;
    sum = col + row_offset(row[1:0]);
    return CMD_SET_ADDR | {1'b0, sum};
  endfunction

endpackage

// ----- src/clcd_in_if.sv -----
// Input channel carrying cursor positioning and text character transactions.
`timescale 1ns / 1ps
interface clcd_in_if
  import clcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [COL_W-1:0]  start_column;
  logic [ROW_W-1:0]  start_row;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, mode, start_column, start_row, char_code, input ready);
  modport sink (input valid, mode, start_column, start_row, char_code, output ready);
endinterface

// ----- src/clcd_out_if.sv -----
// Output channel carrying nibble transactions towards the display bus.
`timescale 1ns / 1ps
interface clcd_out_if
  import clcd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [NIBBLE_W-1:0] nibble;
  logic                reg_select;
  logic                last;

  modport source (output valid, nibble, reg_select, last, input ready);
  modport sink (input valid, nibble, reg_select, last, output ready);
endinterface

// ----- src/clcd_front.sv -----
// Front end: configuration registers, cursor tracking and byte generation per item.
`timescale 1ns / 1ps
module clcd_front
  import clcd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clcd_in_if.sink               in_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output clcd_entry_t           entry_o
);

  logic [COL_W-1:0]    column_count_q;
  logic [ROW_W-1:0]    line_count_q;
  logic [CURSOR_W-1:0] cursor_col_q, cursor_col_d;
  logic [ROW_W-1:0]    cursor_row_q, cursor_row_d;

  logic                wrap;
  logic [ROW_W-1:0]    wrap_row;
  logic [CURSOR_W-1:0] base_col;
  logic [ROW_W-1:0]    base_row;
  logic [CHAR_W-1:0]   final_byte;
  logic                final_rs;

  assign in_if.ready = !q_full_i;
  assign push_o      = in_if.valid && !q_full_i;

  always_comb begin
    wrap     = cursor_col_q >= {1'b0, column_count_q};
    wrap_row = fix_row(cursor_row_q + 3'd1, line_count_q);
    base_col = wrap ? '0 : cursor_col_q;
    base_row = wrap ? wrap_row : cursor_row_q;

    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    final_byte   = '0;
    final_rs     = 1'b0;

    if (!in_if.mode) begin
      cursor_col_d = {1'b0, in_if.start_column};
      cursor_row_d = fix_row(in_if.start_row, line_count_q);
      final_byte   = set_address(cursor_col_d, cursor_row_d);
    end else if (in_if.char_code == CHAR_NEWLINE) begin
      cursor_col_d = base_col;
      cursor_row_d = fix_row(base_row + 3'd1, line_count_q);
      final_byte   = set_address(cursor_col_d, cursor_row_d);
    end else if (in_if.char_code == CHAR_RETURN) begin
      cursor_col_d = '0;
      cursor_row_d = fix_row(base_row, line_count_q);
      final_byte   = set_address(cursor_col_d, cursor_row_d);
    end else begin
      cursor_col_d = base_col + 7'd1;
      cursor_row_d = base_row;
      final_byte   = in_if.char_code;
      final_rs     = 1'b1;
    end

    if (in_if.mode && wrap) begin
      entry_o.two   = 1'b1;
      entry_o.byte0 = set_address('0, wrap_row);
      entry_o.rs0   = 1'b0;
      entry_o.byte1 = final_byte;
      entry_o.rs1   = final_rs;
    end else begin
      entry_o.two   = 1'b0;
      entry_o.byte0 = final_byte;
      entry_o.rs0   = final_rs;
      entry_o.byte1 = final_byte;
      entry_o.rs1   = final_rs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RST;
      line_count_q   <= LINE_COUNT_RST;
      cursor_col_q   <= '0;
      cursor_row_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
          CFG_LINE_COUNT:   line_count_q   <= cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        cursor_col_q <= cursor_col_d;
        cursor_row_q <= cursor_row_d;
      end
    end
  end

endmodule

// ----- src/clcd_queue.sv -----
// Short first-in first-out queue of byte entries between the front and back ends.
`timescale 1ns / 1ps
module clcd_queue
  import clcd_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  clcd_entry_t                  entry_i,
  input  logic                         pop_i,
  output logic                         full_o,
  output logic                         head_valid_o,
  output clcd_entry_t                  head_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  clcd_entry_t         slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o       = count_q == CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_o       = slots_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- src/clcd_back.sv -----
// Back end: splits each queued byte into two nibbles into a registered output stage.
`timescale 1ns / 1ps
module clcd_back
  import clcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  clcd_entry_t       head_i,
  output logic              pop_o,
  output clcd_back_status_t status_o,
  clcd_out_if.source        out_if
);

  logic [1:0]          step_q;
  logic                valid_q;
  logic [NIBBLE_W-1:0] nibble_q, nibble_d;
  logic                rs_q, rs_d;
  logic                last_q, last_d;
  logic                load;
  logic [1:0]          final_step;

  assign load       = head_valid_i && (!valid_q || out_if.ready);
  assign final_step = head_i.two ? 2'd3 : 2'd1;
  assign pop_o      = load && (step_q == final_step);

  always_comb begin
    case (step_q)
      2'd0:    nibble_d = head_i.byte0[7:4];
      2'd1:    nibble_d = head_i.byte0[3:0];
      2'd2:    nibble_d = head_i.byte1[7:4];
      2'd3:    nibble_d = head_i.byte1[3:0];
      default: nibble_d = head_i.byte0[7:4];
    endcase
    rs_d   = step_q[1] ? head_i.rs1 : head_i.rs0;
    last_d = step_q == final_step;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      nibble_q <= nibble_d;
      rs_q     <= rs_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= pop_o ? 2'd0 : step_q + 2'd1;
      end else if (out_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid      = valid_q;
  assign out_if.nibble     = nibble_q;
  assign out_if.reg_select = rs_q;
  assign out_if.last       = last_q;

  assign status_o.step = step_q;
  assign status_o.busy = valid_q;

endmodule

// ----- src/char_lcd_text_writer.sv -----
// Top level of the character LCD text writer with 4-bit nibble output.
`timescale 1ns / 1ps
// Each input transaction either places the cursor or writes one character and
// leaves as two or four nibble transactions, high nibble first, the final one
// flagged with last. The output stage delivers one nibble per cycle while the
// display side is ready, and an item leaves as four nibbles when a pending line
// wrap adds a set-address command before it. The front end takes one item per
// cycle while its queue has room, so short bursts are absorbed without waiting
// for the display side. Configuration is written through cfg_we_i with index 0
// for the column count and 1 for the line count, and must only be changed while
// the block is idle.
module char_lcd_text_writer
  import clcd_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clcd_in_if.sink               in_if,
  clcd_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic                             q_full;
  logic                             push;
  clcd_entry_t                      push_entry;
  logic                             pop;
  logic                             head_valid;
  clcd_entry_t                      head;
  logic [$clog2(QueueDepth+1)-1:0]  q_count;
  clcd_back_status_t                back_status;

  clcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  clcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  clcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .status_o     (back_status),
    .out_if       (out_if)
  );

`ifndef NO_ASSERTIONS
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue occupancy exceeds its depth");

  a_step_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid |-> back_status.step == 2'd0)
    else $error("nibble step left mid-entry with an empty queue");

  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> q_count == $past(q_count) + 1'b1)
    else $error("accepted transaction not recorded in the queue");

  a_last_pops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_if.valid && out_if.last)
    else $error("final nibble not presented after its entry left the queue");
`endif

endmodule

// ----- tb/sv/tb_char_lcd_text_writer.sv -----
// Self-checking testbench of the character LCD text writer with a nibble scoreboard.
`timescale 1ns / 1ps
module tb_char_lcd_text_writer
  import clcd_pkg::*;
;

  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_TEXT  = 1'b1;
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 6;

  typedef struct packed {
    logic              mode;
    logic [COL_W-1:0]  start_column;
    logic [ROW_W-1:0]  start_row;
    logic [CHAR_W-1:0] char_code;
  } lcd_item_t;

  typedef struct packed {
    logic [NIBBLE_W-1:0] nibble;
    logic                reg_select;
    logic                last;
  } lcd_nibble_t;

  class lcd_nibble_board;
    logic [COL_W-1:0]    column_count;
    logic [ROW_W-1:0]    line_count;
    logic [CURSOR_W-1:0] cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    lcd_nibble_t         expected_nibbles[$];
    lcd_nibble_t         item_nibbles[$];
    int unsigned         errors;

    function new();
      column_count  = COLUMN_COUNT_RST;
      line_count    = LINE_COUNT_RST;
      cursor_column = '0;
      cursor_row    = '0;
      errors        = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_COLUMN_COUNT: column_count = value[COL_W-1:0];
        CFG_LINE_COUNT:   line_count = value[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [CHAR_W-1:0] value, logic rs);
      lcd_nibble_t n;
      n.reg_select = rs;
      n.last       = 1'b0;
      n.nibble     = value[7:4];
      item_nibbles.push_back(n);
      n.nibble     = value[3:0];
      item_nibbles.push_back(n);
    endfunction

    function void move_cursor(logic [CURSOR_W-1:0] column, logic [ROW_W-1:0] row);
      logic [ROW_W-1:0]    line;
      logic [CURSOR_W-1:0] offset;
      logic [CURSOR_W-1:0] sum;
      line = (row >= line_count) ? '0 : row;
      cursor_column = column;
      cursor_row    = line;
      case (line[1:0])
        2'd0:    offset = 7'h00;
        2'd1:    offset = 7'h40;
        2'd2:    offset = 7'h14;
        default: offset = 7'h54;
      endcase
      sum = column + offset;
      push_byte(CMD_SET_ADDR | {1'b0, sum}, RS_COMMAND);
    endfunction

    function void note_item(lcd_item_t it);
      lcd_nibble_t n;
      item_nibbles.delete();
      if (it.mode == MODE_PLACE) begin
        move_cursor({1'b0, it.start_column}, it.start_row);
      end else begin
        if (cursor_column >= column_count) move_cursor('0, cursor_row + 1'b1);
        if (it.char_code == CHAR_NEWLINE) begin
          move_cursor(cursor_column, cursor_row + 1'b1);
        end else if (it.char_code == CHAR_RETURN) begin
          move_cursor('0, cursor_row);
        end else begin
          push_byte(it.char_code, RS_DATA);
          cursor_column = cursor_column + 1'b1;
        end
      end
      n = item_nibbles.pop_back();
      n.last = 1'b1;
      item_nibbles.push_back(n);
      foreach (item_nibbles[k]) expected_nibbles.push_back(item_nibbles[k]);
    endfunction

    function void check_nibble(lcd_nibble_t got);
      lcd_nibble_t want;
      if (expected_nibbles.size() == 0) begin
        $error("unexpected nibble transaction: nibble %0h reg_select %0b last %0b",
               got.nibble, got.reg_select, got.last);
        errors++;
        return;
      end
      want = expected_nibbles.pop_front();
      if (got.nibble != want.nibble) begin
        $error("nibble: expected %0h, actual %0h", want.nibble, got.nibble);
        errors++;
      end
      if (got.reg_select != want.reg_select) begin
        $error("reg_select: expected %0b, actual %0b", want.reg_select, got.reg_select);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_nibbles.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  steady;
  int unsigned           cycle_count = 0;
  int unsigned           stall_left = 0;
  lcd_nibble_board       board;

  logic [CFG_DATA_W-1:0] column_settings [PHASES] = '{6'd40, 6'd1, 6'd0, 6'd63, 6'd20, 6'd8};
  logic [CFG_DATA_W-1:0] line_settings   [PHASES] = '{6'd4, 6'd1, 6'd0, 6'd7, 6'd4, 6'h3B};

  clcd_in_if  in_if ();
  clcd_out_if out_if ();

  char_lcd_text_writer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL char_lcd_text_writer");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // The display side stalls at random, except during a steady phase.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = gap_length();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_nibble(lcd_nibble_t'{out_if.nibble, out_if.reg_select, out_if.last});
  end

  task automatic send_item(input lcd_item_t it);
    int unsigned gap;
    gap = gap_length();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.start_column <= it.start_column;
    in_if.start_row    <= it.start_row;
    in_if.char_code    <= it.char_code;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.note_item(it);
  endtask

  task automatic place_at(input logic [COL_W-1:0] column, input logic [ROW_W-1:0] row);
    lcd_item_t it;
    it.mode         = MODE_PLACE;
    it.start_column = column;
    it.start_row    = row;
    it.char_code    = CHAR_W'($urandom);
    send_item(it);
  endtask

  task automatic write_text(input logic [CHAR_W-1:0] code);
    lcd_item_t it;
    it.mode         = MODE_TEXT;
    it.start_column = COL_W'($urandom);
    it.start_row    = ROW_W'($urandom);
    it.char_code    = code;
    send_item(it);
  endtask

  // Holds the sender back until every expected nibble has been delivered.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    board.write_register(index, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_text(input int unsigned count);
    int unsigned pick;
    lcd_item_t   it;
    for (int unsigned k = 0; k < count; k++) begin
      pick            = $urandom_range(0, 99);
      it.mode         = MODE_TEXT;
      it.start_column = COL_W'($urandom);
      it.start_row    = ROW_W'($urandom);
      it.char_code    = CHAR_W'($urandom_range(8'h20, 8'h7E));
      if (pick < 12) it.mode = MODE_PLACE;
      else if (pick < 20) it.char_code = CHAR_NEWLINE;
      else if (pick < 26) it.char_code = CHAR_RETURN;
      else if (pick < 40) it.char_code = CHAR_W'($urandom);
      send_item(it);
    end
  endtask

  initial begin
    board              = new();
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    steady             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_COLUMN_COUNT;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_PLACE;
    in_if.start_column = '0;
    in_if.start_row    = '0;
    in_if.char_code    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: sixteen columns on two lines.
    place_at(6'd0, 3'd0);
    place_at(6'd63, 3'd7);
    write_text(8'h00);
    write_text(8'hFF);
    place_at(6'd15, 3'd1);
    write_text(8'h41);
    write_text(8'h42);
    write_text(CHAR_RETURN);
    place_at(6'd16, 3'd0);
    write_text(CHAR_NEWLINE);
    place_at(6'd20, 3'd1);
    write_text(CHAR_RETURN);
    write_text(CHAR_NEWLINE);
    write_text(8'h7F);
    settle();

    // Writes to unused indexes must leave both registers alone.
    program_register(CFG_SPARE_LO, 6'h3F);
    program_register(CFG_SPARE_HI, 6'h01);
    write_text(8'h80);
    settle();

    // Seven lines let rows four to six be reached; they reuse the offsets of rows zero to two.
    program_register(CFG_LINE_COUNT, 6'd7);
    program_register(CFG_COLUMN_COUNT, 6'd40);
    place_at(6'd10, 3'd4);
    write_text(CHAR_NEWLINE);
    write_text(CHAR_NEWLINE);
    write_text(CHAR_NEWLINE);
    write_text(8'h78);
    settle();

    // With zero columns and zero lines every character wraps to the top line.
    program_register(CFG_LINE_COUNT, 6'd0);
    program_register(CFG_COLUMN_COUNT, 6'd0);
    place_at(6'd5, 3'd3);
    write_text(8'h61);
    write_text(CHAR_NEWLINE);
    write_text(CHAR_RETURN);
    settle();

    for (int unsigned p = 0; p < PHASES; p++) begin
      program_register(CFG_COLUMN_COUNT, column_settings[p]);
      program_register(CFG_LINE_COUNT, line_settings[p]);
      steady = (p == 4);
      random_text(30);
      if (p == 2) settle();
      random_text(30);
      settle();
    end

    if (board.errors == 0) begin
      $display("PASS char_lcd_text_writer");
    end else begin
      $display("FAIL char_lcd_text_writer");
    end
    $finish;
  end

endmodule
